@@ src/afe_pkg.sv @@
`default_nettype none

package afe_pkg;

    localparam int FB_MAX_WIDTH_DEF  = 64;
    localparam int FB_MAX_HEIGHT_DEF = 64;

    localparam int COORD_W    = 12;
    localparam int PIX_W      = 32;
    localparam int CH_W       = 8;
    localparam int ALPHA_W    = 8;
    localparam int DIM_W      = 7;
    localparam int IN_DATA_W  = 4 * COORD_W + PIX_W + ALPHA_W;
    localparam int OUT_DATA_W = PIX_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DIM_W;

    localparam int POS_X_LSB  = 0;
    localparam int POS_Y_LSB  = POS_X_LSB + COORD_W;
    localparam int RECT_W_LSB = POS_Y_LSB + COORD_W;
    localparam int RECT_H_LSB = RECT_W_LSB + COORD_W;
    localparam int COLOR_LSB  = RECT_H_LSB + COORD_W;
    localparam int ALPHA_LSB  = COLOR_LSB + PIX_W;

    localparam logic [ALPHA_W-1:0] ALPHA_FULL   = 8'd255;
    localparam logic [DIM_W-1:0]   ACTIVE_RESET = 7'd64;

    localparam logic OP_FILL = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 1'd1;

    function automatic int addr_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

`default_nettype wire

@@ src/alpha_rect_fill_engine.sv @@
`default_nettype none

// Rectangle fill engine with alpha blending over an internal frame store of
// FB_MAX_WIDTH x FB_MAX_HEIGHT 32-bit pixels held in one RAM (one write port,
// one registered read port). After reset a clearing pass writes zero to every
// pixel, one per cycle; commands are held off until it ends, configuration
// writes are taken at any time. Commands run one at a time. A fill writes
// only the pixels left after clipping; the single RAM write port sets the
// one-pixel-per-cycle pace, and a blend reads, multiplies and writes back
// through a three-deep pipe. Every command returns one result transaction;
// one result may wait at the output while the next command is taken.
module alpha_rect_fill_engine #(
    parameter int FB_MAX_WIDTH  = afe_pkg::FB_MAX_WIDTH_DEF,
    parameter int FB_MAX_HEIGHT = afe_pkg::FB_MAX_HEIGHT_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration write channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [afe_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [afe_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // command stream
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // pos_x[11:0], pos_y[23:12], rect_w[35:24], rect_h[47:36],
    // fill_color[79:48], alpha[87:80]
    input  wire logic [afe_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // op[0]
    input  wire logic                             i_s_tuser,
    // result stream
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // read_data[31:0]
    output logic      [afe_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // was_read[0]
    output logic                                  o_m_tuser
);
    import afe_pkg::*;

    localparam int DEPTH = FB_MAX_WIDTH * FB_MAX_HEIGHT;
    localparam int AW    = addr_bits(DEPTH);
    localparam int SW    = COORD_W + 1;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SETUP = 7'b0000100,
        S_FILL  = 7'b0001000,
        S_DRAIN = 7'b0010000,
        S_FDONE = 7'b0100000,
        S_RESP  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [AW-1:0]      r_clr_addr, n_clr_addr;
    logic [DIM_W-1:0]   r_act_w, r_act_h;

    logic               r_op;
    logic [COORD_W-1:0] r_x, r_y, r_w, r_h;
    logic [PIX_W-1:0]   r_color;
    logic [ALPHA_W-1:0] r_alpha;

    logic [COORD_W-1:0] r_x_last, n_x_last, r_y_last, n_y_last;
    logic [COORD_W-1:0] r_col, n_col, r_row, n_row;
    logic [AW-1:0]      r_base, n_base;
    logic               r_rd_hit, n_rd_hit;

    logic               r_p1_vld;
    logic [AW-1:0]      r_p1_addr;
    logic               r_p2_vld;
    logic [AW-1:0]      r_p2_addr;
    logic [2*CH_W-1:0]  r_p2_fgp [3];
    logic [2*CH_W-1:0]  r_p2_bgp [3];

    logic               r_out_vld;
    logic [PIX_W-1:0]   r_out_data;
    logic               r_out_read;

    logic               s_acc, slot_free, opaque;
    logic [DIM_W-1:0]   fw, fh;
    logic               in_frame;
    logic [SW-1:0]      sum_x, sum_y;
    logic [COORD_W-1:0] end_x, end_y;
    logic [2*SW-1:0]    base_full;
    logic [AW-1:0]      pix_addr;
    logic [ALPHA_W-1:0] alpha_inv;
    logic [PIX_W-1:0]   blend_pix;
    logic [2*CH_W-1:0]  n_fgp [3];
    logic [2*CH_W-1:0]  n_bgp [3];

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [PIX_W-1:0]   ram_wdata, ram_rdata;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign slot_free   = !r_out_vld || i_m_tready;
    assign opaque      = (r_alpha == ALPHA_FULL);
    assign alpha_inv   = ALPHA_FULL - r_alpha;

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_read;

    // clipping against the active frame, limited to the store size
    assign fw = ({6'd0, r_act_w} > SW'(FB_MAX_WIDTH))  ? DIM_W'(FB_MAX_WIDTH)  : r_act_w;
    assign fh = ({6'd0, r_act_h} > SW'(FB_MAX_HEIGHT)) ? DIM_W'(FB_MAX_HEIGHT) : r_act_h;
    assign in_frame = (r_x < COORD_W'(fw)) && (r_y < COORD_W'(fh));
    assign sum_x  = SW'(r_x) + SW'(r_w);
    assign sum_y  = SW'(r_y) + SW'(r_h);
    assign end_x  = (sum_x > SW'(fw)) ? COORD_W'(fw) : sum_x[COORD_W-1:0];
    assign end_y  = (sum_y > SW'(fh)) ? COORD_W'(fh) : sum_y[COORD_W-1:0];
    assign base_full = (2*SW)'(r_y) * (2*SW)'(FB_MAX_WIDTH);
    assign pix_addr  = r_base + AW'(r_col);

    always_comb begin
        logic [2*CH_W:0] sum;
        logic [2*CH_W:0] q;
        blend_pix = '0;
        for (int c = 0; c < 3; c++) begin
            n_fgp[c] = (2*CH_W)'(r_color[c*CH_W +: CH_W]) * (2*CH_W)'(r_alpha);
            n_bgp[c] = (2*CH_W)'(ram_rdata[c*CH_W +: CH_W]) * (2*CH_W)'(alpha_inv);
        end
        for (int c = 0; c < 3; c++) begin
            sum = (2*CH_W+1)'(r_p2_fgp[c]) + (2*CH_W+1)'(r_p2_bgp[c]);
            // exact divide by 255 over the product range
            q = sum + (2*CH_W+1)'(1) + (sum >> CH_W);
            blend_pix[c*CH_W +: CH_W] = q[2*CH_W-1:CH_W];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_x_last   = r_x_last;
        n_y_last   = r_y_last;
        n_col      = r_col;
        n_row      = r_row;
        n_base     = r_base;
        n_rd_hit   = r_rd_hit;
        ram_we     = 1'b0;
        ram_waddr  = pix_addr;
        ram_wdata  = r_color;
        ram_re     = 1'b0;
        ram_raddr  = pix_addr;
        unique case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                if (r_op == OP_READ) begin
                    n_rd_hit  = in_frame;
                    ram_re    = in_frame;
                    ram_raddr = base_full[AW-1:0] + AW'(r_x);
                    n_state   = S_RESP;
                end else if (!in_frame || r_w == '0 || r_h == '0 || r_alpha == '0) begin
                    n_state = S_FDONE;
                end else begin
                    n_col    = r_x;
                    n_row    = r_y;
                    n_base   = base_full[AW-1:0];
                    n_x_last = end_x - COORD_W'(1);
                    n_y_last = end_y - COORD_W'(1);
                    n_state  = S_FILL;
                end
            end
            S_FILL: begin
                ram_we = opaque;
                ram_re = !opaque;
                if (r_col == r_x_last) begin
                    n_col = r_x;
                    if (r_row == r_y_last) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_row  = r_row + COORD_W'(1);
                        n_base = r_base + AW'(FB_MAX_WIDTH);
                    end
                end else begin
                    n_col = r_col + COORD_W'(1);
                end
            end
            S_DRAIN: begin
                if (!r_p1_vld && !r_p2_vld) begin
                    n_state = S_FDONE;
                end
            end
            S_FDONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // blend write-back; never coincides with an opaque or clearing write
        if (r_p2_vld) begin
            ram_we    = 1'b1;
            ram_waddr = r_p2_addr;
            ram_wdata = blend_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_act_w    <= ACTIVE_RESET;
            r_act_h    <= ACTIVE_RESET;
            r_p1_vld   <= 1'b0;
            r_p2_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_ACTIVE_WIDTH:  r_act_w <= i_cfg_data;
                    REG_ACTIVE_HEIGHT: r_act_h <= i_cfg_data;
                    default: ;
                endcase
            end
            r_p1_vld <= (r_state == S_FILL) && !opaque;
            r_p2_vld <= r_p1_vld;
            if ((r_state == S_FDONE || r_state == S_RESP) && slot_free) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_op    <= i_s_tuser;
            r_x     <= i_s_tdata[POS_X_LSB  +: COORD_W];
            r_y     <= i_s_tdata[POS_Y_LSB  +: COORD_W];
            r_w     <= i_s_tdata[RECT_W_LSB +: COORD_W];
            r_h     <= i_s_tdata[RECT_H_LSB +: COORD_W];
            r_color <= i_s_tdata[COLOR_LSB  +: PIX_W];
            r_alpha <= i_s_tdata[ALPHA_LSB  +: ALPHA_W];
        end
        r_x_last  <= n_x_last;
        r_y_last  <= n_y_last;
        r_col     <= n_col;
        r_row     <= n_row;
        r_base    <= n_base;
        r_rd_hit  <= n_rd_hit;
        r_p1_addr <= pix_addr;
        r_p2_addr <= r_p1_addr;
        for (int c = 0; c < 3; c++) begin
            r_p2_fgp[c] <= n_fgp[c];
            r_p2_bgp[c] <= n_bgp[c];
        end
        if (r_state == S_FDONE && slot_free) begin
            r_out_data <= '0;
            r_out_read <= 1'b0;
        end else if (r_state == S_RESP && slot_free) begin
            r_out_data <= r_rd_hit ? ram_rdata : '0;
            r_out_read <= 1'b1;
        end
    end

    afe_ram #(
        .WIDTH(PIX_W),
        .DEPTH(DEPTH)
    ) u_frame_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

endmodule

`default_nettype wire

@@ src/afe_ram.sv @@
`default_nettype none

module afe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [afe_pkg::addr_bits(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic                                 i_re,
    input  wire logic [afe_pkg::addr_bits(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                     o_rdata
);
    import afe_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/afe_checker.sv @@
`default_nettype none

module afe_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    input  wire logic                             o_s_tready,
    input  wire logic                             o_m_tvalid,
    input  wire logic                             i_m_tready,
    input  wire logic [afe_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    input  wire logic                             o_m_tuser
);
    import afe_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // store clearing holds off commands when reset is released
    a_rst_busy: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_s_tready)
        else $error("command taken during clearing pass");

    // one command at a time
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second command taken while busy");

    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("fill result carries data");

endmodule

bind alpha_rect_fill_engine afe_checker u_afe_checker (.*);

`default_nettype wire
